### src/cil_pkg.sv
// Shared types and constants for the curve inverse lookup block.
// No dependencies; used by every module under src.
package cil_pkg;

  localparam int TIME_W = 24;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int KIDX_W = 8;
  localparam int KCNT_W = 9;

  localparam logic [STAT_W-1:0] ST_MATCH = 2'd0;
  localparam logic [STAT_W-1:0] ST_PAST  = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  typedef struct packed {
    logic [TIME_W-1:0]       ktime;
    logic signed [VAL_W-1:0] kval;
  } key_t;

  // interpolation request: key before the match, matching key, target
  typedef struct packed {
    key_t                    pkey;
    key_t                    skey;
    logic signed [VAL_W-1:0] desired;
  } ireq_t;

  typedef struct packed {
    logic              done;
    logic [TIME_W-1:0] mtime;
  } irsp_t;

  typedef struct packed {
    logic              valid;
    logic [TIME_W-1:0] mtime;
    logic [STAT_W-1:0] status;
    logic [KIDX_W-1:0] next_key;
  } result_t;

endpackage

### src/curve_inverse_lookup_interp.sv
// Top level of the curve inverse lookup: key count register, key RAM,
// query sequencer and interpolation unit. Uses cil_pkg and all cil_* modules.
//
//  channel   | handshake                     | payload
//  ----------+-------------------------------+--------------------------------------
//  item in   | start / busy                  | action_i, key_index_i, key_time_i,
//            |                               | key_value_i, desired_distance_i,
//            |                               | start_key_i
//  result    | result_valid_o (1-cycle strobe)| match_time_o, status_o, next_start_key_o
//  config    | cfg_valid_i / cfg_ready_o     | cfg_data_i (key count)
//
// A write item keeps busy low. A query whose start index is out of range answers the
// next cycle, also without raising busy. Otherwise a query walks one key per cycle
// through the RAM read port (registered read data). A match past the start key then
// passes through the interpolation unit (multiply, 24 divide steps, final add and
// clamp). Busy stays high until the result is shown.
// Reset clears the key count and all control; the RAM needs no clearing.
// The receiver cannot stall: each result is shown for exactly one cycle.
module curve_inverse_lookup_interp #(
  parameter int MAX_KEYS = 256
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic                               action_i,
  input  logic [cil_pkg::KIDX_W-1:0]         key_index_i,
  input  logic [cil_pkg::TIME_W-1:0]         key_time_i,
  input  logic signed [cil_pkg::VAL_W-1:0]   key_value_i,
  input  logic signed [cil_pkg::VAL_W-1:0]   desired_distance_i,
  input  logic [cil_pkg::KIDX_W-1:0]         start_key_i,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [cil_pkg::KCNT_W-1:0]         cfg_data_i,
  output logic                               result_valid_o,
  output logic [cil_pkg::TIME_W-1:0]         match_time_o,
  output logic [cil_pkg::STAT_W-1:0]         status_o,
  output logic [cil_pkg::KIDX_W-1:0]         next_start_key_o
);

  localparam int IW   = $clog2(MAX_KEYS);
  localparam int CNTW = $clog2(MAX_KEYS + 1);
  localparam int TW   = (CNTW > cil_pkg::KCNT_W) ? CNTW : cil_pkg::KCNT_W;

  logic [cil_pkg::KCNT_W-1:0] key_count_q;
  logic [CNTW-1:0]            cnt_eff;
  logic                       item_xfer, wr_en, qry;
  logic [IW-1:0]              raddr;
  cil_pkg::key_t              wdata, rdata;
  logic                       ireq_valid;
  cil_pkg::ireq_t             ireq;
  cil_pkg::irsp_t             irsp;
  cil_pkg::result_t           res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      key_count_q <= cfg_data_i;
    end
  end

  assign cnt_eff = (TW'(key_count_q) < TW'(MAX_KEYS)) ? CNTW'(key_count_q) : CNTW'(MAX_KEYS);

  assign item_xfer = start && !busy;
  assign wr_en     = item_xfer && (action_i == cil_pkg::ACT_WRITE)
                   && (TW'(key_index_i) < TW'(MAX_KEYS));
  assign qry       = item_xfer && (action_i == cil_pkg::ACT_QUERY);

  assign wdata.ktime = key_time_i;
  assign wdata.kval  = key_value_i;

  cil_key_mem #(
    .DEPTH (MAX_KEYS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (IW'(key_index_i)),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  cil_walk #(
    .MAX_KEYS (MAX_KEYS)
  ) u_walk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .qry_i        (qry),
    .start_key_i  (start_key_i),
    .desired_i    (desired_distance_i),
    .cnt_i        (cnt_eff),
    .rdata_i      (rdata),
    .raddr_o      (raddr),
    .busy_o       (busy),
    .ireq_valid_o (ireq_valid),
    .ireq_o       (ireq),
    .irsp_i       (irsp),
    .res_o        (res)
  );

  cil_interp u_interp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (ireq_valid),
    .req_data_i (ireq),
    .rsp_o      (irsp)
  );

  assign result_valid_o   = res.valid;
  assign match_time_o     = res.mtime;
  assign status_o         = res.status;
  assign next_start_key_o = res.next_key;

endmodule

### src/cil_key_mem.sv
// Key table: one synchronous RAM holding time and value of each curve key.
// Uses cil_pkg::key_t. One write port, one read port, registered read data.
module cil_key_mem #(
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  cil_pkg::key_t wdata_i,
  input  logic [AW-1:0] raddr_i,
  output cil_pkg::key_t rdata_o
);

  cil_pkg::key_t mem [DEPTH];
  cil_pkg::key_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/cil_interp.sv
// Interpolation unit: prepares differences, one 24x32 multiply, then a
// restoring divide at one quotient bit per cycle. Uses cil_pkg.
module cil_interp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_i,
  input  cil_pkg::ireq_t req_data_i,
  output cil_pkg::irsp_t rsp_o
);

  localparam int TW     = cil_pkg::TIME_W;
  localparam int VW     = cil_pkg::VAL_W;
  localparam int PROD_W = TW + VW;
  localparam int STEP_W = $clog2(TW);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [TW-1:0]     dt_mag_q, tp_q, qsh_q, qsh_d;
  logic              dt_neg_q;
  logic [VW-1:0]     num_mag_q, dv_mag_q, rem_q, rem_d;

  // differences of the incoming request
  logic signed [TW:0] dt_s;
  logic signed [VW:0] num_s, dv_s;
  logic [TW-1:0]      dt_mag;
  logic [VW-1:0]      num_mag, dv_mag;

  assign dt_s  = $signed({1'b0, req_data_i.skey.ktime}) - $signed({1'b0, req_data_i.pkey.ktime});
  assign num_s = $signed({req_data_i.desired[VW-1], req_data_i.desired})
               - $signed({req_data_i.pkey.kval[VW-1], req_data_i.pkey.kval});
  assign dv_s  = $signed({req_data_i.skey.kval[VW-1], req_data_i.skey.kval})
               - $signed({req_data_i.pkey.kval[VW-1], req_data_i.pkey.kval});
  assign dt_mag  = dt_s[TW]  ? TW'(-dt_s)  : dt_s[TW-1:0];
  assign num_mag = num_s[VW] ? VW'(-num_s) : num_s[VW-1:0];
  assign dv_mag  = dv_s[VW]  ? VW'(-dv_s)  : dv_s[VW-1:0];

  logic [PROD_W-1:0] prod;
  assign prod = dt_mag_q * num_mag_q;

  // restoring divide step
  logic [VW:0]   trial;
  logic [VW+1:0] diff;
  logic          ge;
  assign trial = {rem_q, qsh_q[TW-1]};
  assign diff  = {1'b0, trial} - {2'b00, dv_mag_q};
  assign ge    = ~diff[VW+1];

  // final add and clamp; quotient carries the sign of the time difference
  logic signed [TW+1:0] sum;
  logic [TW-1:0]        sat;
  assign sum = dt_neg_q ? $signed({2'b00, tp_q}) - $signed({2'b00, qsh_q})
                        : $signed({2'b00, tp_q}) + $signed({2'b00, qsh_q});
  always_comb begin
    if (sum[TW+1]) begin
      sat = '0;
    end else if (sum[TW]) begin
      sat = cil_pkg::TIME_MAX;
    end else begin
      sat = sum[TW-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    rem_d   = rem_q;
    qsh_d   = qsh_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_i) state_d = S_MUL;
      end
      S_MUL: begin
        rem_d   = prod[PROD_W-1:TW];
        qsh_d   = prod[TW-1:0];
        step_d  = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        rem_d  = ge ? diff[VW-1:0] : trial[VW-1:0];
        qsh_d  = {qsh_q[TW-2:0], ge};
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(TW - 1)) state_d = S_FIN;
      end
      S_FIN: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q <= step_d;
    rem_q  <= rem_d;
    qsh_q  <= qsh_d;
    if (state_q == S_IDLE && req_i) begin
      dt_mag_q  <= dt_mag;
      dt_neg_q  <= dt_s[TW];
      num_mag_q <= num_mag;
      dv_mag_q  <= dv_mag;
      tp_q      <= req_data_i.pkey.ktime;
    end
  end

  assign rsp_o.done  = (state_q == S_FIN);
  assign rsp_o.mtime = sat;

  // the matched key lies at or below the target, the key before lies above
  a_num_le_dv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL) |-> (num_mag_q <= dv_mag_q && dv_mag_q != '0))
    else $error("interpolation numerator exceeds key value step");

  a_rem_lt_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (rem_q < dv_mag_q))
    else $error("divider remainder out of range");

  a_req_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i |-> (state_q == S_IDLE))
    else $error("interpolation request while unit busy");

endmodule

### src/cil_walk.sv
// Query sequencer: walks the key table one entry per cycle through the RAM
// read port; a match past the start key hands the bracketing keys to cil_interp. Uses cil_pkg.
module cil_walk #(
  parameter int MAX_KEYS = 256,
  localparam int IW   = $clog2(MAX_KEYS),
  localparam int CNTW = $clog2(MAX_KEYS + 1)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                qry_i,
  input  logic [cil_pkg::KIDX_W-1:0]          start_key_i,
  input  logic signed [cil_pkg::VAL_W-1:0]    desired_i,
  input  logic [CNTW-1:0]                     cnt_i,
  input  cil_pkg::key_t                       rdata_i,
  output logic [IW-1:0]                       raddr_o,
  output logic                                busy_o,
  output logic                                ireq_valid_o,
  output cil_pkg::ireq_t                      ireq_o,
  input  cil_pkg::irsp_t                      irsp_i,
  output cil_pkg::result_t                    res_o
);

  localparam int KW   = cil_pkg::KIDX_W;
  localparam int CMPW = (CNTW > KW) ? CNTW : KW;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_WALK   = 2'd1;
  localparam logic [1:0] S_INTERP = 2'd2;

  logic [1:0]                     state_q, state_d;
  logic [IW-1:0]                  idx_q, idx_d, start_q;
  logic [KW-1:0]                  start_key_q;
  logic signed [cil_pkg::VAL_W-1:0] desired_q;
  logic [CNTW-1:0]                cnt_q;
  cil_pkg::key_t                  prev_q, prev_d;
  logic                           res_valid_q, res_valid_d;
  logic [cil_pkg::TIME_W-1:0]     res_time_q, res_time_d;
  logic [cil_pkg::STAT_W-1:0]     res_stat_q, res_stat_d;
  logic [KW-1:0]                  res_next_q, res_next_d;

  logic out_of_range, hit, last, accept;

  assign out_of_range = CMPW'(start_key_i) >= CMPW'(cnt_i);
  assign hit          = !($signed(rdata_i.kval) > desired_q);
  assign last         = (CNTW'(idx_q) + CNTW'(1)) == cnt_q;
  assign accept       = (state_q == S_IDLE) && qry_i && !out_of_range;

  // read data always belongs to the index in idx_q while walking
  assign raddr_o = (state_q == S_IDLE) ? IW'(start_key_i) : IW'(idx_q + 1'b1);

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    prev_d       = prev_q;
    res_valid_d  = 1'b0;
    res_time_d   = res_time_q;
    res_stat_d   = res_stat_q;
    res_next_d   = res_next_q;
    ireq_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (qry_i) begin
          if (out_of_range) begin
            res_valid_d = 1'b1;
            res_time_d  = '0;
            res_stat_d  = cil_pkg::ST_RANGE;
            res_next_d  = start_key_i;
          end else begin
            idx_d   = IW'(start_key_i);
            state_d = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (hit) begin
          if (idx_q == start_q) begin
            // start key already qualifies: no step to interpolate over
            res_valid_d = 1'b1;
            res_time_d  = rdata_i.ktime;
            res_stat_d  = cil_pkg::ST_MATCH;
            res_next_d  = KW'(idx_q);
            state_d     = S_IDLE;
          end else begin
            ireq_valid_o = 1'b1;
            state_d      = S_INTERP;
          end
        end else begin
          prev_d = rdata_i;
          if (last) begin
            res_valid_d = 1'b1;
            res_time_d  = rdata_i.ktime;
            res_stat_d  = cil_pkg::ST_PAST;
            res_next_d  = start_key_q;
            state_d     = S_IDLE;
          end else begin
            idx_d = IW'(idx_q + 1'b1);
          end
        end
      end
      S_INTERP: begin
        if (irsp_i.done) begin
          res_valid_d = 1'b1;
          res_time_d  = irsp_i.mtime;
          res_stat_d  = cil_pkg::ST_MATCH;
          res_next_d  = KW'(idx_q);
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    prev_q     <= prev_d;
    res_time_q <= res_time_d;
    res_stat_q <= res_stat_d;
    res_next_q <= res_next_d;
    if (accept) begin
      start_q     <= IW'(start_key_i);
      start_key_q <= start_key_i;
      desired_q   <= desired_i;
      cnt_q       <= cnt_i;
    end
  end

  assign busy_o         = (state_q != S_IDLE);
  assign ireq_o.pkey    = prev_q;
  assign ireq_o.skey    = rdata_i;
  assign ireq_o.desired = desired_q;

  assign res_o.valid    = res_valid_q;
  assign res_o.mtime    = res_time_q;
  assign res_o.status   = res_stat_q;
  assign res_o.next_key = res_next_q;

  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> (CNTW'(idx_q) < cnt_q))
    else $error("walk index beyond key count");

  a_interp_not_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ireq_valid_o |-> (idx_q != start_q))
    else $error("interpolation launched without a previous key");

  a_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_stat_q == cil_pkg::ST_RANGE) |-> (res_time_q == '0))
    else $error("out of range result carries a nonzero time");

endmodule

### bench/testbench.sv
// Self-checking bench for curve_inverse_lookup_interp: directed rows, then random
// curves and queries, each result checked against a fixed expectation or an in-bench lookup predictor.
// Depends on cil_pkg and the RTL under src.
`timescale 1ns / 100ps

module testbench;

  localparam int N_KEYS      = 256;
  localparam int N_RANDOM    = 1050;
  localparam int PHASE_ITEMS = 90;
  localparam int SETTLE      = 300;        // longest walk plus divide
  localparam int LIMIT       = 3_000_000;
  localparam logic signed [cil_pkg::VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [cil_pkg::VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic                             action;
    logic [cil_pkg::KIDX_W-1:0]       kidx;
    logic [cil_pkg::TIME_W-1:0]       ktime;
    logic signed [cil_pkg::VAL_W-1:0] kval;
    logic signed [cil_pkg::VAL_W-1:0] desired;
    logic [cil_pkg::KIDX_W-1:0]       skey;
  } key_item_t;

  typedef struct packed {
    logic [cil_pkg::TIME_W-1:0] mtime;
    logic [cil_pkg::STAT_W-1:0] status;
    logic [cil_pkg::KIDX_W-1:0] nkey;
  } lookup_t;

  typedef struct packed {
    logic                       is_cfg;
    logic [cil_pkg::KCNT_W-1:0] cnt;
    key_item_t                  item;
    logic                       typed;
    lookup_t                    want;
  } row_t;

  logic                             clk_i;
  logic                             rst_ni;
  logic                             start;
  logic                             busy;
  logic                             action_i;
  logic [cil_pkg::KIDX_W-1:0]       key_index_i;
  logic [cil_pkg::TIME_W-1:0]       key_time_i;
  logic signed [cil_pkg::VAL_W-1:0] key_value_i;
  logic signed [cil_pkg::VAL_W-1:0] desired_distance_i;
  logic [cil_pkg::KIDX_W-1:0]       start_key_i;
  logic                             cfg_valid_i;
  logic                             cfg_ready_o;
  logic [cil_pkg::KCNT_W-1:0]       cfg_data_i;
  logic                             result_valid_o;
  logic [cil_pkg::TIME_W-1:0]       match_time_o;
  logic [cil_pkg::STAT_W-1:0]       status_o;
  logic [cil_pkg::KIDX_W-1:0]       next_start_key_o;

  // predictor state
  logic [cil_pkg::TIME_W-1:0]       key_time_mem [N_KEYS];
  logic signed [cil_pkg::VAL_W-1:0] key_val_mem  [N_KEYS];
  logic [cil_pkg::KCNT_W-1:0]       key_count;

  lookup_t pending_lookups[$];
  row_t    directed_rows[$];
  lookup_t want_r;
  int      fail_count;
  int      items_sent;
  int      burst_left;
  bit      steady_phase;

  curve_inverse_lookup_interp u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .action_i           (action_i),
    .key_index_i        (key_index_i),
    .key_time_i         (key_time_i),
    .key_value_i        (key_value_i),
    .desired_distance_i (desired_distance_i),
    .start_key_i        (start_key_i),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_data_i         (cfg_data_i),
    .result_valid_o     (result_valid_o),
    .match_time_o       (match_time_o),
    .status_o           (status_o),
    .next_start_key_o   (next_start_key_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t: %s", $time, msg);
  endfunction

  // walk from the start key to the first key at or below the target, then interpolate
  function automatic lookup_t predict_lookup(input logic signed [cil_pkg::VAL_W-1:0] target,
                                             input logic [cil_pkg::KIDX_W-1:0] skey);
    int      n, i, p, s;
    bit      found;
    longint  pv, dv, dt, res;
    lookup_t r;
    n = (key_count > N_KEYS) ? N_KEYS : int'(key_count);
    r.nkey = skey;
    r.mtime = '0;
    r.status = cil_pkg::ST_RANGE;
    if (int'(skey) >= n) return r;
    p = int'(skey);
    s = int'(skey);
    found = 1'b0;
    for (i = int'(skey); i < n && !found; i++) begin
      if (key_val_mem[i] > target) p = i;
      else begin
        s = i;
        found = 1'b1;
      end
    end
    if (!found) begin
      r.mtime = key_time_mem[p];
      r.status = cil_pkg::ST_PAST;
      return r;
    end
    pv = longint'(key_val_mem[p]);
    dv = longint'(key_val_mem[s]) - pv;
    r.status = cil_pkg::ST_MATCH;
    r.nkey = s[cil_pkg::KIDX_W-1:0];
    if (dv == 0) begin
      r.mtime = key_time_mem[p];
    end else begin
      dt = longint'(key_time_mem[s]) - longint'(key_time_mem[p]);
      res = longint'(key_time_mem[p]) + (dt * (longint'(target) - pv)) / dv;
      if (res < 0) res = 0;
      if (res > longint'(cil_pkg::TIME_MAX)) res = longint'(cil_pkg::TIME_MAX);
      r.mtime = res[cil_pkg::TIME_W-1:0];
    end
    return r;
  endfunction

  function automatic key_item_t junk_item();
    key_item_t it;
    it.action  = 1'($urandom_range(0, 1));
    it.kidx    = cil_pkg::KIDX_W'($urandom);
    it.ktime   = cil_pkg::TIME_W'($urandom);
    it.kval    = $urandom;
    it.desired = $urandom;
    it.skey    = cil_pkg::KIDX_W'($urandom);
    return it;
  endfunction

  // one transfer; predictor is updated at the accepting edge
  task automatic issue(input key_item_t it, input logic typed, input lookup_t want);
    @(negedge clk_i);
    start              <= 1'b1;
    action_i           <= it.action;
    key_index_i        <= it.kidx;
    key_time_i         <= it.ktime;
    key_value_i        <= it.kval;
    desired_distance_i <= it.desired;
    start_key_i        <= it.skey;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (it.action == cil_pkg::ACT_QUERY) begin
      pending_lookups.push_back(typed ? want : predict_lookup(it.desired, it.skey));
    end else begin
      key_time_mem[it.kidx] = it.ktime;
      key_val_mem[it.kidx]  = it.kval;
    end
    items_sent++;
  endtask

  task automatic pause(input int n);
    key_item_t it;
    it = junk_item();
    @(negedge clk_i);
    start              <= 1'b0;
    action_i           <= it.action;
    key_index_i        <= it.kidx;
    key_value_i        <= it.kval;
    desired_distance_i <= it.desired;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic send(input key_item_t it, input logic typed, input lookup_t want);
    if (!steady_phase && burst_left == 0) begin
      pause($urandom_range(1, 10));
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    issue(it, typed, want);
  endtask

  task automatic write_key_count(input logic [cil_pkg::KCNT_W-1:0] cnt);
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_lookups.size() != 0 || busy) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= cnt;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    key_count = cnt;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // non-rising values, non-falling times; zero steps and clamping at the floor give runs of equal values
  task automatic build_curve(input int n);
    longint    v, t;
    int        sh, tsh, k;
    key_item_t it;
    v = ($urandom_range(0, 3) == 0) ? longint'(VAL_MAX) : longint'(int'($urandom));
    t = ($urandom_range(0, 3) == 0) ? longint'($urandom_range(0, 24'hFF_FFFF))
                                    : longint'($urandom_range(0, 16'hFFFF));
    sh = $urandom_range(0, 26);
    tsh = $urandom_range(0, 18);
    for (k = 0; k < n; k++) begin
      it = junk_item();
      it.action = cil_pkg::ACT_WRITE;
      it.kidx   = k[cil_pkg::KIDX_W-1:0];
      it.ktime  = t[cil_pkg::TIME_W-1:0];
      it.kval   = v[cil_pkg::VAL_W-1:0];
      send(it, 1'b0, '0);
      v -= longint'($urandom_range(0, 1 << sh));
      if (v < longint'(VAL_MIN)) v = longint'(VAL_MIN);
      t += longint'($urandom_range(0, 1 << tsh));
      if (t > longint'(cil_pkg::TIME_MAX)) t = longint'(cil_pkg::TIME_MAX);
    end
  endtask

  task automatic random_item(input int n);
    key_item_t it;
    int        roll, j;
    longint    gap, d;
    it = junk_item();
    roll = $urandom_range(0, 99);
    if (roll < 15) begin
      it.action = cil_pkg::ACT_WRITE;        // stray rewrite of any key
    end else begin
      it.action = cil_pkg::ACT_QUERY;
      if (roll >= 22 && n > 0) begin
        it.skey = cil_pkg::KIDX_W'($urandom_range(0, n - 1));
        j = $urandom_range(int'(it.skey), n - 1);
        roll = $urandom_range(0, 99);
        if (roll < 50) begin
          gap = (j > int'(it.skey)) ? longint'(key_val_mem[j-1]) - longint'(key_val_mem[j])
                                    : 64;
          if (gap < 0) gap = 64;
          d = longint'(key_val_mem[j]) + longint'($urandom_range(0, 32'(gap)));
          if (d > longint'(VAL_MAX)) d = longint'(VAL_MAX);
          it.desired = d[cil_pkg::VAL_W-1:0];
        end else if (roll < 70) begin
          it.desired = key_val_mem[j];
        end else if (roll < 80) begin
          it.desired = $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
        end
      end
    end
    send(it, 1'b0, '0);
  endtask

  function automatic void add_cfg(input logic [cil_pkg::KCNT_W-1:0] cnt);
    row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.cnt = cnt;
    directed_rows.push_back(r);
  endfunction

  function automatic void add_wr(input logic [cil_pkg::KIDX_W-1:0] idx,
                                 input logic [cil_pkg::TIME_W-1:0] t,
                                 input logic signed [cil_pkg::VAL_W-1:0] v);
    row_t r;
    r = '0;
    r.item = junk_item();
    r.item.action = cil_pkg::ACT_WRITE;
    r.item.kidx = idx;
    r.item.ktime = t;
    r.item.kval = v;
    directed_rows.push_back(r);
  endfunction

  function automatic void add_q(input logic signed [cil_pkg::VAL_W-1:0] target,
                                input logic [cil_pkg::KIDX_W-1:0] skey, input logic typed,
                                input lookup_t want);
    row_t r;
    r = '0;
    r.item = junk_item();
    r.item.action = cil_pkg::ACT_QUERY;
    r.item.desired = target;
    r.item.skey = skey;
    r.typed = typed;
    r.want = want;
    directed_rows.push_back(r);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (pending_lookups.size() == 0) begin
        note_failure($sformatf("unexpected result time=%h status=%0d next=%0d",
                               match_time_o, status_o, next_start_key_o));
      end else begin
        want_r = pending_lookups.pop_front();
        if (match_time_o !== want_r.mtime || status_o !== want_r.status ||
            next_start_key_o !== want_r.nkey)
          note_failure($sformatf(
            "mismatch: want time=%h status=%0d next=%0d, got time=%h status=%0d next=%0d",
            want_r.mtime, want_r.status, want_r.nkey,
            match_time_o, status_o, next_start_key_o));
      end
    end
  end

  initial begin : watchdog
    int cycles;
    for (cycles = 0; cycles < LIMIT; cycles++) @(posedge clk_i);
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    int base, cnt;
    int sched [5] = '{2, 256, 511, 0, 1};
    int phase;
    rst_ni             = 1'b0;
    start              = 1'b0;
    action_i           = cil_pkg::ACT_WRITE;
    key_index_i        = '0;
    key_time_i         = '0;
    key_value_i        = '0;
    desired_distance_i = '0;
    start_key_i        = '0;
    cfg_valid_i        = 1'b0;
    cfg_data_i         = '0;
    key_count          = '0;
    fail_count         = 0;
    items_sent         = 0;
    burst_left         = 0;
    steady_phase       = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // every key written once so no query ever reads an empty entry; count stays 0
    build_curve(N_KEYS);

    // directed rows
    add_q(32'sd0, 8'd0, 1'b1, {24'h0, cil_pkg::ST_RANGE, 8'd0});        // empty table
    add_q(VAL_MAX, 8'd255, 1'b1, {24'h0, cil_pkg::ST_RANGE, 8'd255});
    add_wr(8'd0, 24'h00_0000, VAL_MAX);
    add_wr(8'd1, 24'h01_0000, 32'sd1000);
    add_wr(8'd2, 24'h02_0000, 32'sd0);
    add_wr(8'd3, 24'hFF_FFFF, VAL_MIN);
    add_wr(8'd4, 24'h03_0000, VAL_MIN);
    add_cfg(9'd4);
    // start key already qualifies
    add_q(VAL_MAX, 8'd0, 1'b1, {24'h0, cil_pkg::ST_MATCH, 8'd0});
    add_q(32'sd500, 8'd0, 1'b0, '0);
    add_q(VAL_MIN, 8'd1, 1'b0, '0);
    add_q(VAL_MIN, 8'd3, 1'b1, {24'hFF_FFFF, cil_pkg::ST_MATCH, 8'd3});
    add_q(32'sd0, 8'd4, 1'b1, {24'h0, cil_pkg::ST_RANGE, 8'd4});
    add_q(-32'sd1, 8'd0, 1'b0, '0);
    add_cfg(9'd3);
    // nothing qualifies
    add_q(-32'sd1, 8'd1, 1'b1, {24'h02_0000, cil_pkg::ST_PAST, 8'd1});
    add_q(32'sd1, 8'd2, 1'b1, {24'h02_0000, cil_pkg::ST_MATCH, 8'd2});
    add_q(32'sd0, 8'd0, 1'b0, '0);
    add_cfg(9'd256);
    add_q(VAL_MIN, 8'd255, 1'b0, '0);
    add_q(VAL_MAX, 8'd0, 1'b1, {24'h0, cil_pkg::ST_MATCH, 8'd0});
    add_cfg(9'd511);                                            // clipped to table size
    add_q(32'sd12345, 8'd5, 1'b0, '0);
    add_q(VAL_MIN, 8'd200, 1'b0, '0);
    add_cfg(9'd1);
    add_q(VAL_MIN, 8'd0, 1'b1, {24'h0, cil_pkg::ST_PAST, 8'd0});
    add_q(VAL_MIN, 8'd1, 1'b1, {24'h0, cil_pkg::ST_RANGE, 8'd1});
    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) write_key_count(directed_rows[i].cnt);
      else send(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
    end

    // random phases: fresh count and curve, then queries mixed with stray writes
    base = items_sent;
    phase = 0;
    while (items_sent - base < N_RANDOM) begin
      if (phase < 5) cnt = sched[phase];
      else if ($urandom_range(0, 99) < 70) cnt = $urandom_range(1, 40);
      else if ($urandom_range(0, 1) == 0) cnt = $urandom_range(41, 255);
      else cnt = $urandom_range(256, 511);
      phase++;
      write_key_count(cnt[cil_pkg::KCNT_W-1:0]);
      steady_phase = ($urandom_range(0, 3) == 0);
      cnt = (cnt > N_KEYS) ? N_KEYS : cnt;
      build_curve(cnt);
      repeat (PHASE_ITEMS) random_item(cnt);
    end

    @(negedge clk_i);
    start <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

### filelist.f
src/cil_pkg.sv
src/cil_key_mem.sv
src/cil_interp.sv
src/cil_walk.sv
src/curve_inverse_lookup_interp.sv
bench/testbench.sv
